// ----- src/mpfec_pkg.sv -----
// shared types and constants of the mtu packetizer with xor parity and packet cache
// depends on nothing; imported by the front end, back end and top level
package mpfec_pkg;

  // command codes on in_command
  localparam logic [1:0] CMD_DATA   = 2'd0;
  localparam logic [1:0] CMD_PARITY = 2'd1;
  localparam logic [1:0] CMD_CACHE  = 2'd2;

  // tags of the parity packet
  localparam logic [7:0] KIND_PARITY   = 8'hFE;
  localparam logic [7:0] NUMBER_PARITY = 8'hFF;

  // widths that cover the whole legal range of the top level parameters
  localparam int SIZE_W_MAX   = 14;  // packet size up to 9000
  localparam int PAR_AW_MAX   = 14;  // parity buffer address
  localparam int SLOT_W_MAX   = 12;  // cache slot, up to 4096 slots
  localparam int PAY_AW_MAX   = 26;  // payload memory address

  typedef enum logic [1:0] {
    OP_NONE,
    OP_DATA,
    OP_PARITY,
    OP_CACHE
  } op_t;

  typedef enum logic [1:0] {
    PAR_NONE,
    PAR_LOAD,
    PAR_XOR
  } par_op_t;

  // packet header as kept in the cache and carried with every byte
  typedef struct packed {
    logic                  valid;
    logic [15:0]           seq;
    logic [31:0]           stamp;
    logic [7:0]            kind;
    logic [7:0]            num;
    logic [7:0]            tot;
    logic [SIZE_W_MAX-1:0] size;
  } hdr_t;

  // one classified transaction handed from the front end to the back end
  typedef struct packed {
    op_t                   op;
    par_op_t               par_op;
    logic [PAR_AW_MAX-1:0] par_addr;
    logic                  hdr_we;
    logic [SLOT_W_MAX-1:0] slot;
    logic [PAY_AW_MAX-1:0] pay_addr;
    hdr_t                  hdr;
    logic [7:0]            data;
    logic                  lp;
    logic                  lf;
    logic [15:0]           req;
    logic [10:0]           off;
  } item_t;

  // one result transaction
  typedef struct packed {
    logic        hit;
    logic [15:0] seq;
    logic [31:0] stamp;
    logic [7:0]  kind;
    logic [7:0]  num;
    logic [7:0]  tot;
    logic [10:0] size;
    logic [7:0]  data;
    logic        lp;
    logic        lf;
  } result_t;

endpackage

// ----- src/mpfec_fifo.sv -----
// small register fifo used between front and back end and as the result queue
// depends on nothing but its type parameter
module mpfec_fifo #(
  parameter type T = logic,
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  T                           push_data,
  input  logic                       pop,
  output T                           head,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  T                mem_r [DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;
  logic            do_pop;

  assign do_pop = pop && (cnt_r != '0);
  assign head   = mem_r[rp_r];
  assign empty  = (cnt_r == '0);
  assign count  = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH-1)) ? '0 : wp_r + PW'(1);
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH-1)) ? '0 : rp_r + PW'(1);
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (!push && do_pop) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end
endmodule

// ----- src/mpfec_front.sv -----
// front end: accepts commands, computes packet totals, runs the packetizer counters
// and classifies each transaction into an item_t; uses mpfec_pkg
module mpfec_front #(
  parameter int MTU_BYTES = 1400,
  parameter int CACHE_PACKETS = 512,
  parameter int QDEPTH = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [1:0]                  in_command,
  input  logic [7:0]                  in_data_byte,
  input  logic [18:0]                 in_frame_length,
  input  logic [31:0]                 in_frame_time,
  input  logic [7:0]                  in_frame_kind,
  input  logic [15:0]                 in_request_sequence,
  input  logic [10:0]                 in_read_offset,
  input  logic                        clearing,
  input  logic [$clog2(QDEPTH+1)-1:0] q_count,
  output logic                        q_push,
  output mpfec_pkg::item_t            q_item
);
  import mpfec_pkg::*;

  localparam int PW  = $clog2(MTU_BYTES);
  localparam int SW  = $clog2(MTU_BYTES+1);
  localparam int CW  = $clog2(CACHE_PACKETS);
  localparam int AW  = $clog2(CACHE_PACKETS*MTU_BYTES);
  localparam int QCW = $clog2(QDEPTH+1) + 2;
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / MTU_BYTES);

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  data;
    logic [18:0] len;
    logic [31:0] stamp;
    logic [7:0]  kind;
    logic [15:0] req;
    logic [10:0] off;
  } fin_t;

  typedef struct packed {
    logic [15:0]   seq;
    logic [CW-1:0] slot;
    logic [AW-1:0] base;
  } ptr_t;

  function automatic ptr_t ptr_inc(ptr_t p);
    ptr_t r;
    r.seq = p.seq + 16'd1;
    if (p.seq == 16'hFFFF) begin
      r.slot = '0;
      r.base = '0;
    end else if (p.slot == CW'(CACHE_PACKETS-1)) begin
      r.slot = '0;
      r.base = '0;
    end else begin
      r.slot = p.slot + CW'(1);
      r.base = p.base + AW'(MTU_BYTES);
    end
    return r;
  endfunction

  // pipeline toward the state stage
  logic        v0_r, v1_r, v2_r;
  fin_t        f0_r, f1_r, f2_r;
  logic [19:0] n1_r, q1_r, q2_r, r2_r;
  logic [19:0] n0, qm;
  logic [52:0] prod;
  logic [2:0]  inflight;
  logic [QCW-1:0] occ;

  // packetizer state
  ptr_t        next_r, next_nxt, cur_r, cur_nxt;
  logic [18:0] fpos_r, fpos_nxt, len_r, len_nxt;
  logic [31:0] time_r, time_nxt, ptime_r, ptime_nxt;
  logic [7:0]  kind_r, kind_nxt, idx_r, idx_nxt, tot_r, tot_nxt, ptot_r, ptot_nxt;
  logic [PW-1:0] bip_r, bip_nxt;
  logic [SW-1:0] size_r, size_nxt;
  logic        bld_r, bld_nxt, pv_r, pv_nxt;
  logic [15:0] pseq_r, pseq_nxt;

  // data byte step
  logic        first, bld, bld_e, pv_e, lp, lf, fend;
  logic [18:0] l_len, rem, fpos_e;
  logic [31:0] l_time, ptime_e;
  logic [7:0]  l_kind, l_tot, idx, idx_e, t8, ptot_e;
  logic [19:0] tot_full, fp_n;
  logic [PW-1:0] bip, bip_e;
  logic [SW-1:0] size;
  ptr_t        pn, cur;
  logic [15:0] pseq_e;

  assign inflight = 3'(v0_r) + 3'(v1_r) + 3'(v2_r);
  assign occ      = QCW'(q_count) + QCW'(inflight);
  assign in_full  = clearing || (occ >= QCW'(QDEPTH));

  // ceil(len / mtu) by reciprocal: estimate, then one correction
  assign n0   = {1'b0, f0_r.len} + 20'(MTU_BYTES-1);
  assign prod = n0 * RECIP;
  assign qm   = 20'(q1_r * 20'(MTU_BYTES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= in_push && !in_full;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    f0_r.cmd   <= in_command;
    f0_r.data  <= in_data_byte;
    f0_r.len   <= (in_frame_length == '0) ? 19'd1 : in_frame_length;
    f0_r.stamp <= in_frame_time;
    f0_r.kind  <= in_frame_kind;
    f0_r.req   <= in_request_sequence;
    f0_r.off   <= in_read_offset;
    f1_r <= f0_r;
    n1_r <= n0;
    q1_r <= prod[51:32];
    f2_r <= f1_r;
    q2_r <= q1_r;
    r2_r <= n1_r - qm;
  end

  always_comb begin
    tot_full = (r2_r >= 20'(MTU_BYTES)) ? q2_r + 20'd1 : q2_r;
    t8       = tot_full[7:0];
    first    = (fpos_r == '0);
    l_len    = first ? f2_r.len : len_r;
    l_time   = first ? f2_r.stamp : time_r;
    l_kind   = first ? f2_r.kind : kind_r;
    l_tot    = first ? ((t8 == '0) ? 8'd1 : t8) : tot_r;
    idx      = first ? 8'd0 : idx_r;
    bip      = first ? '0 : bip_r;
    bld      = first ? ((f2_r.kind == 8'd0) && (f2_r.len > 19'(MTU_BYTES))) : bld_r;
    pv_e     = (first && bld) ? 1'b0 : pv_r;
    rem      = l_len - fpos_r;
    pn       = next_r;
    if (bip == '0) begin
      size = (rem > 19'(MTU_BYTES)) ? SW'(MTU_BYTES) : SW'(rem);
      cur  = next_r;
      pn   = ptr_inc(next_r);
    end else begin
      size = size_r;
      cur  = cur_r;
    end
    lp     = (SW'(bip) + SW'(1)) == size;
    fp_n   = {1'b0, fpos_r} + 20'd1;
    lf     = (fp_n == {1'b0, l_len});
    fend   = lf || (fp_n >= {1'b0, l_len});
    bip_e  = lp ? '0 : bip + PW'(1);
    idx_e  = lp ? idx + 8'd1 : idx;
    fpos_e = fp_n[18:0];
    bld_e  = bld;
    pseq_e = pseq_r;
    ptime_e = ptime_r;
    ptot_e = ptot_r;
    if (fend) begin
      // frame done: a parity packet being built is closed and takes the next sequence number
      if (bld) begin
        pv_e    = 1'b1;
        pseq_e  = pn.seq;
        pn      = ptr_inc(pn);
        ptime_e = l_time;
        ptot_e  = idx_e;
        bld_e   = 1'b0;
      end
      fpos_e = '0;
      bip_e  = '0;
      idx_e  = '0;
    end
  end

  always_comb begin
    next_nxt  = next_r;
    cur_nxt   = cur_r;
    fpos_nxt  = fpos_r;
    len_nxt   = len_r;
    time_nxt  = time_r;
    kind_nxt  = kind_r;
    idx_nxt   = idx_r;
    tot_nxt   = tot_r;
    bip_nxt   = bip_r;
    size_nxt  = size_r;
    bld_nxt   = bld_r;
    pv_nxt    = pv_r;
    pseq_nxt  = pseq_r;
    ptime_nxt = ptime_r;
    ptot_nxt  = ptot_r;
    q_item    = '0;
    q_item.op = OP_NONE;
    q_item.par_op = PAR_NONE;
    q_push    = v2_r;
    if (v2_r) begin
      case (f2_r.cmd)
        CMD_DATA: begin
          next_nxt  = pn;
          cur_nxt   = cur;
          fpos_nxt  = fpos_e;
          len_nxt   = l_len;
          time_nxt  = l_time;
          kind_nxt  = l_kind;
          idx_nxt   = idx_e;
          tot_nxt   = l_tot;
          bip_nxt   = bip_e;
          size_nxt  = size;
          bld_nxt   = bld_e;
          pv_nxt    = pv_e;
          pseq_nxt  = pseq_e;
          ptime_nxt = ptime_e;
          ptot_nxt  = ptot_e;
          q_item.op       = OP_DATA;
          q_item.hdr_we   = (bip == '0);
          q_item.slot     = SLOT_W_MAX'(cur.slot);
          q_item.pay_addr = PAY_AW_MAX'(cur.base + AW'(bip));
          q_item.hdr      = '{valid: 1'b1, seq: cur.seq, stamp: l_time, kind: l_kind,
                              num: idx, tot: l_tot, size: SIZE_W_MAX'(size)};
          q_item.data     = f2_r.data;
          q_item.lp       = lp;
          q_item.lf       = lf;
          q_item.par_addr = PAR_AW_MAX'(bip);
          if (bld) begin
            q_item.par_op = (fpos_r < 19'(MTU_BYTES)) ? PAR_LOAD : PAR_XOR;
          end
        end
        CMD_PARITY: begin
          if (pv_r) begin
            q_item.op       = OP_PARITY;
            q_item.hdr      = '{valid: 1'b1, seq: pseq_r, stamp: ptime_r, kind: KIND_PARITY,
                                num: NUMBER_PARITY, tot: ptot_r,
                                size: SIZE_W_MAX'(MTU_BYTES)};
            q_item.lp       = (15'(f2_r.off) + 15'd1) == 15'(MTU_BYTES);
            q_item.par_addr = PAR_AW_MAX'(f2_r.off);
            q_item.off      = f2_r.off;
          end
        end
        CMD_CACHE: begin
          q_item.op  = OP_CACHE;
          q_item.req = f2_r.req;
          q_item.off = f2_r.off;
        end
        default: begin
          q_item.op = OP_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_r  <= '0;
      cur_r   <= '0;
      fpos_r  <= '0;
      len_r   <= '0;
      time_r  <= '0;
      kind_r  <= '0;
      idx_r   <= '0;
      tot_r   <= '0;
      bip_r   <= '0;
      size_r  <= '0;
      bld_r   <= 1'b0;
      pv_r    <= 1'b0;
      pseq_r  <= '0;
      ptime_r <= '0;
      ptot_r  <= '0;
    end else begin
      next_r  <= next_nxt;
      cur_r   <= cur_nxt;
      fpos_r  <= fpos_nxt;
      len_r   <= len_nxt;
      time_r  <= time_nxt;
      kind_r  <= kind_nxt;
      idx_r   <= idx_nxt;
      tot_r   <= tot_nxt;
      bip_r   <= bip_nxt;
      size_r  <= size_nxt;
      bld_r   <= bld_nxt;
      pv_r    <= pv_nxt;
      pseq_r  <= pseq_nxt;
      ptime_r <= ptime_nxt;
      ptot_r  <= ptot_nxt;
    end
  end
endmodule

// ----- src/mpfec_back.sv -----
// back end: cache slot lookup, header/payload/parity memories and result forming
// uses mpfec_pkg; fed by the item queue, drives the result queue
module mpfec_back #(
  parameter int MTU_BYTES = 1400,
  parameter int CACHE_PACKETS = 512,
  parameter int ODEPTH = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  mpfec_pkg::item_t            q_head,
  output logic                        q_pop,
  input  logic [$clog2(ODEPTH+1)-1:0] res_count,
  output logic                        res_push,
  output mpfec_pkg::result_t          res,
  output logic                        clearing
);
  import mpfec_pkg::*;

  localparam int PW   = $clog2(MTU_BYTES);
  localparam int CW   = $clog2(CACHE_PACKETS);
  localparam int AW   = $clog2(CACHE_PACKETS*MTU_BYTES);
  localparam int OCW  = $clog2(ODEPTH+1) + 3;
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / CACHE_PACKETS);

  logic        v0_r, v1_r, v2_r, v3_r, v4_r;
  item_t       s0_r, s1_r, s2_r, s3_r, s4_r, s3_in;
  logic [48:0] prod;
  logic [15:0] q1_r;
  logic [16:0] rem2_r, rem_fix;
  logic [CW-1:0] slot2;
  logic [3:0]  inflight;
  logic [OCW-1:0] occ;

  logic          clearing_r;
  logic [CW-1:0] clr_r;

  hdr_t        hdr_mem [CACHE_PACKETS];
  logic [7:0]  pay_mem [CACHE_PACKETS*MTU_BYTES];
  logic [7:0]  par_mem [MTU_BYTES];
  hdr_t        hdr_q_r, hdr_wd;
  logic [7:0]  pay_q_r, par_q_r;
  logic        hdr_we;
  logic [CW-1:0] hdr_wa;

  logic          fwd_v_r;
  logic [PW-1:0] fwd_a_r;
  logic [7:0]    fwd_d_r, par_rd, par_wd;
  logic          par_we;
  logic          hit;

  assign clearing = clearing_r;
  assign inflight = 4'(v0_r) + 4'(v1_r) + 4'(v2_r) + 4'(v3_r) + 4'(v4_r);
  assign occ      = OCW'(res_count) + OCW'(inflight);
  assign q_pop    = !q_empty && !clearing_r && (occ < OCW'(ODEPTH));

  // slot = req mod cache_packets: reciprocal estimate, then one correction
  assign prod    = s0_r.req * RECIP;
  assign rem_fix = (rem2_r >= 17'(CACHE_PACKETS)) ? rem2_r - 17'(CACHE_PACKETS) : rem2_r;
  assign slot2   = CW'(rem_fix);

  always_comb begin
    s3_in = s2_r;
    if (s2_r.op == OP_CACHE) begin
      s3_in.slot     = SLOT_W_MAX'(slot2);
      s3_in.pay_addr = PAY_AW_MAX'(AW'(slot2 * MTU_BYTES) + AW'(s2_r.off));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      clearing_r <= 1'b1;
      clr_r <= '0;
    end else begin
      v0_r <= q_pop;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      if (clearing_r) begin
        clr_r <= clr_r + CW'(1);
        if (clr_r == CW'(CACHE_PACKETS-1)) begin
          clearing_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s0_r   <= q_head;
    s1_r   <= s0_r;
    q1_r   <= prod[47:32];
    s2_r   <= s1_r;
    rem2_r <= {1'b0, s1_r.req} - 17'(q1_r * 16'(CACHE_PACKETS));
    s3_r   <= s3_in;
    s4_r   <= s3_r;
  end

  // header memory: clearing pass after reset, else written on a packet's first byte
  always_comb begin
    hdr_we = clearing_r || (v3_r && (s3_r.op == OP_DATA) && s3_r.hdr_we);
    hdr_wa = clearing_r ? clr_r : s3_r.slot[CW-1:0];
    hdr_wd = clearing_r ? '0 : s3_r.hdr;
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_mem[hdr_wa] <= hdr_wd;
    end
    hdr_q_r <= hdr_mem[s3_r.slot[CW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (v3_r && (s3_r.op == OP_DATA)) begin
      pay_mem[s3_r.pay_addr[AW-1:0]] <= s3_r.data;
    end
    pay_q_r <= pay_mem[s3_r.pay_addr[AW-1:0]];
  end

  // parity read-modify-write: read in stage 3, write in stage 4, last write forwarded
  assign par_rd = (fwd_v_r && (fwd_a_r == s4_r.par_addr[PW-1:0])) ? fwd_d_r : par_q_r;
  assign par_we = v4_r && (s4_r.op == OP_DATA) && (s4_r.par_op != PAR_NONE);
  assign par_wd = (s4_r.par_op == PAR_XOR) ? (par_rd ^ s4_r.data) : s4_r.data;

  always_ff @(posedge clk) begin
    if (par_we) begin
      par_mem[s4_r.par_addr[PW-1:0]] <= par_wd;
    end
    par_q_r <= par_mem[s3_r.par_addr[PW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r <= 1'b0;
    end else if (par_we) begin
      fwd_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (par_we) begin
      fwd_a_r <= s4_r.par_addr[PW-1:0];
      fwd_d_r <= par_wd;
    end
  end

  assign hit = hdr_q_r.valid && (hdr_q_r.seq == s4_r.req);

  always_comb begin
    res      = '0;
    res_push = v4_r;
    case (s4_r.op)
      OP_DATA, OP_PARITY: begin
        res.hit   = 1'b1;
        res.seq   = s4_r.hdr.seq;
        res.stamp = s4_r.hdr.stamp;
        res.kind  = s4_r.hdr.kind;
        res.num   = s4_r.hdr.num;
        res.tot   = s4_r.hdr.tot;
        res.size  = s4_r.hdr.size[10:0];
        res.lp    = s4_r.lp;
        if (s4_r.op == OP_DATA) begin
          res.data = s4_r.data;
          res.lf   = s4_r.lf;
        end else begin
          res.data = (15'(s4_r.off) < 15'(MTU_BYTES)) ? par_rd : 8'd0;
        end
      end
      OP_CACHE: begin
        if (hit) begin
          res.hit   = 1'b1;
          res.seq   = s4_r.req;
          res.stamp = hdr_q_r.stamp;
          res.kind  = hdr_q_r.kind;
          res.num   = hdr_q_r.num;
          res.tot   = hdr_q_r.tot;
          res.size  = hdr_q_r.size[10:0];
          res.data  = ((15'(s4_r.off) < 15'(hdr_q_r.size))
                       && (15'(s4_r.off) < 15'(MTU_BYTES))) ? pay_q_r : 8'd0;
          res.lp    = (15'(s4_r.off) + 15'd1) == 15'(hdr_q_r.size);
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end
endmodule

// ----- src/mtu_packetizer_xor_fec_arq_cache_top.sv -----
// top level of the mtu packetizer with xor parity and retransmission cache
// depends on mpfec_pkg, mpfec_fifo, mpfec_front and mpfec_back
//
// Cuts frame bytes (command 0) into packets of up to MTU_BYTES payload bytes and echoes
// every byte with its packet tags; each packet is stored in a ring cache of CACHE_PACKETS
// slots indexed by sequence number, and key frames of more than one packet build an xor
// parity packet that takes one extra sequence number. Command 1 reads a parity byte,
// command 2 reads a cached byte by sequence number with a hit flag. Both sides look like
// queues: a transaction is taken when in_push is high and in_full low, and a result leaves
// when out_pop is high and out_empty low. One transaction per clock is sustained, with
// every command, while results are popped and the clearing sweep is over; a result shows
// up on the out ports after its transaction passes three front stages for the packet
// count, the item queue, five back stages for the slot lookup and the memory read and
// parity read-modify-write, then the write into the result queue. After reset the block
// sweeps the cache header memory, one slot per cycle, and in_full stays high until it ends.
module mtu_packetizer_xor_fec_arq_cache_top #(
  parameter int MTU_BYTES = 1400,
  parameter int CACHE_PACKETS = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_data_byte,
  input  logic [18:0] in_frame_length,
  input  logic [31:0] in_frame_time,
  input  logic [7:0]  in_frame_kind,
  input  logic [15:0] in_request_sequence,
  input  logic [10:0] in_read_offset,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_hit,
  output logic [15:0] out_packet_sequence,
  output logic [31:0] out_packet_time,
  output logic [7:0]  out_packet_kind,
  output logic [7:0]  out_packet_number,
  output logic [7:0]  out_packet_total,
  output logic [10:0] out_packet_size,
  output logic [7:0]  out_data_out,
  output logic        out_last_in_packet,
  output logic        out_last_in_frame
);
  import mpfec_pkg::*;

  // queue depths cover the pipeline stages so neither side stalls in steady state
  localparam int QDEPTH = 8;
  localparam int ODEPTH = 8;

  // front end to item queue
  logic                        f_push;
  item_t                       f_item;
  // item queue to back end
  item_t                       q_head;
  logic                        q_empty, q_pop;
  logic [$clog2(QDEPTH+1)-1:0] q_count;
  // back end to result queue
  logic                        r_push;
  result_t                     r_data, r_head;
  logic [$clog2(ODEPTH+1)-1:0] r_count;
  logic                        clearing;

  mpfec_front #(
    .MTU_BYTES(MTU_BYTES),
    .CACHE_PACKETS(CACHE_PACKETS),
    .QDEPTH(QDEPTH)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_command         (in_command),
    .in_data_byte       (in_data_byte),
    .in_frame_length    (in_frame_length),
    .in_frame_time      (in_frame_time),
    .in_frame_kind      (in_frame_kind),
    .in_request_sequence(in_request_sequence),
    .in_read_offset     (in_read_offset),
    .clearing           (clearing),
    .q_count            (q_count),
    .q_push             (f_push),
    .q_item             (f_item)
  );

  // classified transactions wait here for the back end
  mpfec_fifo #(
    .T(item_t),
    .DEPTH(QDEPTH)
  ) u_item_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .push_data(f_item),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .count    (q_count)
  );

  mpfec_back #(
    .MTU_BYTES(MTU_BYTES),
    .CACHE_PACKETS(CACHE_PACKETS),
    .ODEPTH(ODEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .res_count(r_count),
    .res_push (r_push),
    .res      (r_data),
    .clearing (clearing)
  );

  // result queue; the back end only issues when a slot here is reserved
  mpfec_fifo #(
    .T(result_t),
    .DEPTH(ODEPTH)
  ) u_res_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (r_push),
    .push_data(r_data),
    .pop      (out_pop),
    .head     (r_head),
    .empty    (out_empty),
    .count    (r_count)
  );

  assign out_hit             = r_head.hit;
  assign out_packet_sequence = r_head.seq;
  assign out_packet_time     = r_head.stamp;
  assign out_packet_kind     = r_head.kind;
  assign out_packet_number   = r_head.num;
  assign out_packet_total    = r_head.tot;
  assign out_packet_size     = r_head.size;
  assign out_data_out        = r_head.data;
  assign out_last_in_packet  = r_head.lp;
  assign out_last_in_frame   = r_head.lf;
endmodule

// ----- src/mpfec_checker.sv -----
// port level checks for the packetizer top level, bound to every instance
// depends only on the top level's ports
module mpfec_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_push,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic        out_hit,
  input logic [15:0] out_packet_sequence,
  input logic [7:0]  out_data_out,
  input logic [10:0] out_packet_size,
  input logic        out_last_in_packet,
  input logic        out_last_in_frame
);
  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data_out)
      && $stable(out_packet_sequence)))
    else $error("result changed while waiting");

  // reset leaves no results and a full input during the clearing sweep
  a_reset: assert property (@(posedge clk)
    !rst_n |=> (out_empty && in_full))
    else $error("not empty and full after reset");

  // a miss carries all-zero tags
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_hit) |-> (out_packet_sequence == 16'd0 && out_data_out == 8'd0
      && out_packet_size == 11'd0 && !out_last_in_packet))
    else $error("miss with nonzero fields");

  // end of frame only on a data byte, which always hits
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_last_in_frame) |-> out_hit)
    else $error("frame end without hit");
endmodule

bind mtu_packetizer_xor_fec_arq_cache_top mpfec_checker u_checker (.*);
